// ===== rtl/core/spdpid_pkg.sv =====
// shared types and constants for the speed pid unit
`timescale 1ns / 1ps
package spdpid_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PPR    = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_ICLAMP = 3'd4;
  localparam logic [2:0] REG_STEP   = 3'd5;

  localparam int CountsPerPulse = 4;
  localparam int RpmScale       = 6000;
  localparam int PidScale       = 25600;

  // serial divider and multiplier widths
  localparam int SpdW   = 36;  // |count_delta| * 6000
  localparam int DenW   = 18;  // pulses_per_rev * counts per pulse
  localparam int PwRemW = 23;  // positive pid sum below the 255 cap
  localparam int GainW  = 16;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b0_0000_0001,
    ST_SPDIV = 9'b0_0000_0010,
    ST_SPEED = 9'b0_0000_0100,
    ST_ERR   = 9'b0_0000_1000,
    ST_MULP  = 9'b0_0001_0000,
    ST_MULI  = 9'b0_0010_0000,
    ST_MULD  = 9'b0_0100_0000,
    ST_PWDIV = 9'b0_1000_0000,
    ST_OUT   = 9'b1_0000_0000
  } state_t;

endpackage

// ===== rtl/core/speed_pid_with_rate_limit_unit.sv =====
// speed pid controller with pwm slew limit, top level
`timescale 1ns / 1ps
// One encoder window in, one word out. The speed is count*6000/(ppr*4),
// truncated and saturated; the pid runs on setpoint minus |speed| with Q8.8
// gains, clamped integral, output clamped to 0..255 and slew limited. The
// divisions and gain products are bit-serial: one quotient bit or one gain bit
// per cycle. A pid item runs the speed division, saturation, error and
// integral, the three gain products, a check of the sum and the divide by
// 25600 (skipped when the sum is not positive or over the cap), then loads
// the output word. A loop-held item skips the pid after saturation. The next
// item is taken only once the output word is loaded. A new item is taken
// while the previous result waits; the unit only stalls in its output state
// while an older word is still unread. Register writes are taken only while
// the unit is idle.
module speed_pid_with_rate_limit_unit import spdpid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // count_delta[23:0], target_rpm_x10[39:24], present_pwm[47:40]
  input  logic        in_tuser,   // loop_enable
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // speed_rpm_x10[31:0], drive_pwm[39:32]
  output logic        out_tuser,  // drive_updated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] ppr_r, iclamp_r;
  logic signed [15:0] gp_r, gi_r, gd_r;
  logic [7:0]  step_r;
  logic signed [31:0] integ_r, lerr_r;

  state_t state_r;
  logic [5:0] cnt_r;

  // captured item
  logic [15:0] tgt_r;
  logic        run_r;
  logic [7:0]  pres_r;
  logic        neg_r;

  // speed divide: dividend shifts out as the quotient shifts in
  logic [SpdW-1:0] quo_r;
  logic [DenW-1:0] rem_r;
  logic [31:0]     speed_r;
  logic [32:0]     spd_mag_r;

  // gain products, accumulated straight into the sum
  logic signed [33:0] diff_r;
  logic signed [63:0] mcand_r, sum_r;
  logic [GainW-1:0]   mplier_r;

  // output divide by 25600
  logic [PwRemW-1:0] pw_rem_r;
  logic [PwRemW-2:0] pw_div_r;
  logic [7:0]        want_r;

  logic [31:0] res_speed_r;
  logic [7:0]  res_pwm_r;
  logic        res_upd_r, out_valid_r;

  // helper terms
  logic [15:0] ppr_eff;
  logic [DenW-1:0] den;
  logic [23:0] cnt_mag;
  logic [SpdW-1:0] num_mag;
  logic [DenW:0] rem_sh, rem_sub;
  logic spd_over;
  logic [31:0] spd_sat;
  logic [32:0] mag_sat;
  logic signed [32:0] err_full;
  logic signed [33:0] acc_full, lim_s, clamped, diff_full;
  logic signed [63:0] term;
  logic pw_ge;
  logic signed [9:0] delta, stp;
  logic [7:0] slew_pwm;
  logic out_load;

  assign cfg_ready  = (state_r == ST_IDLE);
  assign in_tready  = (state_r == ST_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_pwm_r, res_speed_r};
  assign out_tuser  = res_upd_r;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    // speed numerator and divider step
    ppr_eff = (ppr_r == 16'd0) ? 16'd1 : ppr_r;
    den     = DenW'(ppr_eff) * DenW'(CountsPerPulse);
    cnt_mag = in_tdata[23] ? (~in_tdata[23:0] + 24'd1) : in_tdata[23:0];
    num_mag = SpdW'(cnt_mag) * SpdW'(RpmScale);
    rem_sh  = {rem_r, quo_r[SpdW-1]};
    rem_sub = rem_sh - {1'b0, den};
    // saturate the signed speed to 32 bits
    spd_over = neg_r ? ((|quo_r[SpdW-1:32]) || (quo_r[31] && (|quo_r[30:0])))
                     : (|quo_r[SpdW-1:31]);
    if (spd_over) begin
      spd_sat = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag_sat = neg_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    end else begin
      spd_sat = neg_r ? (~quo_r[31:0] + 32'd1) : quo_r[31:0];
      mag_sat = {1'b0, quo_r[31:0]};
    end
    // error, clamped integral and difference
    err_full  = $signed({17'd0, tgt_r}) - $signed(spd_mag_r);
    acc_full  = 34'(integ_r) + 34'(err_full);
    lim_s     = $signed({18'd0, iclamp_r}) * 34'sd100;
    clamped   = (acc_full > lim_s) ? lim_s : ((acc_full < -lim_s) ? -lim_s : acc_full);
    diff_full = 34'(err_full) - 34'(lerr_r);
    // gain sign bit carries negative weight
    term  = (cnt_r == 6'(GainW - 1)) ? -mcand_r : mcand_r;
    pw_ge = ({1'b0, pw_div_r} <= pw_rem_r);
    // slew limit around the present duty
    delta = $signed({2'b00, want_r}) - $signed({2'b00, pres_r});
    stp   = $signed({2'b00, step_r});
    if (delta > stp) begin
      slew_pwm = pres_r + step_r;
    end else if (delta < -stp) begin
      slew_pwm = pres_r - step_r;
    end else begin
      slew_pwm = want_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r <= 16'd14; gp_r <= '0; gi_r <= '0; gd_r <= '0;
      iclamp_r <= 16'd255; step_r <= 8'd10;
      integ_r <= '0; lerr_r <= '0;
      state_r <= ST_IDLE; cnt_r <= '0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PPR:    ppr_r    <= cfg_data;
          REG_GAIN_P: gp_r     <= cfg_data;
          REG_GAIN_I: gi_r     <= cfg_data;
          REG_GAIN_D: gd_r     <= cfg_data;
          REG_ICLAMP: iclamp_r <= cfg_data;
          REG_STEP:   step_r   <= cfg_data[7:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            tgt_r   <= in_tdata[39:24];
            pres_r  <= in_tdata[47:40];
            run_r   <= in_tuser && (in_tdata[39:24] != 16'd0);
            neg_r   <= in_tdata[23];
            quo_r   <= num_mag;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= ST_SPDIV;
          end
        end
        ST_SPDIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sub[DenW]) begin
            rem_r <= rem_sh[DenW-1:0];
            quo_r <= {quo_r[SpdW-2:0], 1'b0};
          end else begin
            rem_r <= rem_sub[DenW-1:0];
            quo_r <= {quo_r[SpdW-2:0], 1'b1};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(SpdW - 1)) state_r <= ST_SPEED;
        end
        ST_SPEED: begin
          speed_r   <= spd_sat;
          spd_mag_r <= mag_sat;
          if (!run_r) begin
            // loop held: clear the loop state
            integ_r <= '0; lerr_r <= '0;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_ERR;
          end
        end
        ST_ERR: begin
          integ_r  <= clamped[31:0];
          lerr_r   <= err_full[31:0];
          diff_r   <= diff_full;
          // p term: gain_p * err * 10
          mcand_r  <= 64'(err_full) * 64'sd10;
          mplier_r <= gp_r;
          sum_r    <= '0;
          cnt_r    <= '0;
          state_r  <= ST_MULP;
        end
        ST_MULP, ST_MULI, ST_MULD: begin
          // signed gain times operand, one gain bit per cycle
          if (mplier_r[0]) sum_r <= sum_r + term;
          if (cnt_r != 6'(GainW - 1)) begin
            mplier_r <= mplier_r >> 1;
            mcand_r  <= mcand_r <<< 1;
            cnt_r    <= cnt_r + 6'd1;
          end else begin
            cnt_r <= '0;
            if (state_r == ST_MULP) begin
              mcand_r  <= 64'(integ_r);
              mplier_r <= gi_r;
              state_r  <= ST_MULI;
            end else if (state_r == ST_MULI) begin
              mcand_r  <= 64'(diff_r) * 64'sd100;
              mplier_r <= gd_r;
              state_r  <= ST_MULD;
            end else begin
              state_r <= ST_PWDIV;
            end
          end
        end
        ST_PWDIV: begin
          if (cnt_r == 6'd0) begin
            // non-positive sum gives 0, a sum at or past the cap gives 255
            if (sum_r <= 64'sd0) begin
              want_r  <= 8'd0;
              state_r <= ST_OUT;
            end else if (sum_r >= 64'(PidScale * 256)) begin
              want_r  <= 8'd255;
              state_r <= ST_OUT;
            end else begin
              pw_rem_r <= sum_r[PwRemW-1:0];
              pw_div_r <= (PwRemW-1)'(PidScale * 128);
              want_r   <= 8'd0;
              cnt_r    <= 6'd1;
            end
          end else begin
            // eight quotient bits, divisor shifts down
            if (pw_ge) pw_rem_r <= pw_rem_r - {1'b0, pw_div_r};
            want_r   <= {want_r[6:0], pw_ge};
            pw_div_r <= pw_div_r >> 1;
            cnt_r    <= cnt_r + 6'd1;
            if (cnt_r == 6'd8) state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            res_speed_r <= speed_r;
            res_pwm_r   <= run_r ? slew_pwm : pres_r;
            res_upd_r   <= run_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output word valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
